// File: rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

    // Number formats
    localparam int FRAC_BITS   = 16;
    localparam int IN_W        = 18;
    localparam int CH_W        = 8;
    localparam int UNIT_W      = FRAC_BITS + 1;
    localparam int HUE_SECTORS = 6;
    localparam int H6_W        = FRAC_BITS + 3;
    localparam int EXT_W       = (IN_W > FRAC_BITS) ? IN_W : FRAC_BITS;
    localparam int CMP_W       = ((IN_W > UNIT_W) ? IN_W : UNIT_W) + 1;
    localparam int PROD_W      = 2 * UNIT_W;

    localparam logic [UNIT_W-1:0] ONE = UNIT_W'(1) << FRAC_BITS;

    // Hue sector, 0..5 around the color wheel
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    // Front end to mix stage
    typedef struct packed {
        logic [UNIT_W-1:0] val;
        logic [UNIT_W-1:0] one_m_s;
        logic [UNIT_W-1:0] sf;
        logic [UNIT_W-1:0] s_one_m_f;
        sector_t           sec;
        logic [CH_W-1:0]   alpha;
    } front_t;

    // Mix stage to output stage
    typedef struct packed {
        logic [UNIT_W-1:0] val;
        logic [UNIT_W-1:0] p;
        logic [UNIT_W-1:0] q;
        logic [UNIT_W-1:0] t;
        sector_t           sec;
        logic [CH_W-1:0]   alpha;
    } mix_t;

endpackage

`default_nettype wire

// File: rtl/hsvrgb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [hsvrgb_pkg::IN_W-1:0]    hue;
    logic signed [hsvrgb_pkg::IN_W-1:0]    saturation;
    logic signed [hsvrgb_pkg::IN_W-1:0]    brightness;
    logic        [hsvrgb_pkg::CH_W-1:0]    alpha_in;

    modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
    modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

`default_nettype wire

// File: rtl/hsvrgb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_out_if;
    logic                           valid;
    logic                           ready;
    logic [hsvrgb_pkg::CH_W-1:0]    red;
    logic [hsvrgb_pkg::CH_W-1:0]    green;
    logic [hsvrgb_pkg::CH_W-1:0]    blue;
    logic [hsvrgb_pkg::CH_W-1:0]    alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

// File: rtl/hsvrgb_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Stages 1 and 2: clamp, hue sector split, saturation products
module hsvrgb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hsvrgb_in_if.sink            pix_in,
    output logic                 fr_valid,
    input  wire logic            fr_ready,
    output hsvrgb_pkg::front_t   fr_data
);

    function automatic logic [hsvrgb_pkg::UNIT_W-1:0] clamp_unit(
        input logic signed [hsvrgb_pkg::IN_W-1:0] x
    );
        logic [hsvrgb_pkg::CMP_W-1:0] xe;
        logic [hsvrgb_pkg::CMP_W-1:0] one_e;
        xe    = hsvrgb_pkg::CMP_W'(x);
        one_e = hsvrgb_pkg::CMP_W'(hsvrgb_pkg::ONE);
        if (xe[hsvrgb_pkg::CMP_W-1])
            return '0;
        else if (xe > one_e)
            return hsvrgb_pkg::ONE;
        else
            return hsvrgb_pkg::UNIT_W'(xe);
    endfunction

    // Stage 1 registers
    logic                              s1_valid_reg;
    logic [hsvrgb_pkg::UNIT_W-1:0]     s1_sat_reg;
    logic [hsvrgb_pkg::UNIT_W-1:0]     s1_val_reg;
    hsvrgb_pkg::sector_t               s1_sec_reg;
    logic [hsvrgb_pkg::FRAC_BITS-1:0]  s1_frac_reg;
    logic [hsvrgb_pkg::CH_W-1:0]       s1_alpha_reg;

    // Stage 2 registers
    logic                              s2_valid_reg;
    hsvrgb_pkg::front_t                s2_data_reg;

    logic s1_ready;
    logic s2_ready;

    logic signed [hsvrgb_pkg::EXT_W-1:0] hue_ext;
    logic [hsvrgb_pkg::FRAC_BITS-1:0]    hue_frac;
    logic [hsvrgb_pkg::H6_W-1:0]         h6_next;

    logic [hsvrgb_pkg::UNIT_W-1:0]       one_m_f;
    logic [hsvrgb_pkg::PROD_W-1:0]       sf_prod;
    logic [hsvrgb_pkg::PROD_W-1:0]       s1f_prod;
    hsvrgb_pkg::front_t                  s2_data_next;

    assign s2_ready     = !s2_valid_reg || fr_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign pix_in.ready = s1_ready;

    // Hue: keep the fraction (wrap mod one), scale by six
    assign hue_ext  = hsvrgb_pkg::EXT_W'(pix_in.hue);
    assign hue_frac = hue_ext[hsvrgb_pkg::FRAC_BITS-1:0];
    assign h6_next  = hsvrgb_pkg::H6_W'(hue_frac) * hsvrgb_pkg::H6_W'(hsvrgb_pkg::HUE_SECTORS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= pix_in.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && pix_in.valid)
        begin
            s1_sat_reg   <= clamp_unit(pix_in.saturation);
            s1_val_reg   <= clamp_unit(pix_in.brightness);
            s1_sec_reg   <= hsvrgb_pkg::sector_t'(
                                h6_next[hsvrgb_pkg::H6_W-1:hsvrgb_pkg::FRAC_BITS]);
            s1_frac_reg  <= h6_next[hsvrgb_pkg::FRAC_BITS-1:0];
            s1_alpha_reg <= pix_in.alpha_in;
        end
    end

    // Stage 2: s*f and s*(1-f), each scaled back by one
    assign one_m_f  = hsvrgb_pkg::ONE - hsvrgb_pkg::UNIT_W'(s1_frac_reg);
    assign sf_prod  = hsvrgb_pkg::PROD_W'(s1_sat_reg) * hsvrgb_pkg::PROD_W'(s1_frac_reg);
    assign s1f_prod = hsvrgb_pkg::PROD_W'(s1_sat_reg) * hsvrgb_pkg::PROD_W'(one_m_f);

    always_comb
    begin
        s2_data_next.val       = s1_val_reg;
        s2_data_next.one_m_s   = hsvrgb_pkg::ONE - s1_sat_reg;
        s2_data_next.sf        = hsvrgb_pkg::UNIT_W'(sf_prod >> hsvrgb_pkg::FRAC_BITS);
        s2_data_next.s_one_m_f = hsvrgb_pkg::UNIT_W'(s1f_prod >> hsvrgb_pkg::FRAC_BITS);
        s2_data_next.sec       = s1_sec_reg;
        s2_data_next.alpha     = s1_alpha_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

    assign fr_valid = s2_valid_reg;
    assign fr_data  = s2_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsvrgb_mix.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: p, q and t as brightness times the scaled factors
module hsvrgb_mix (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fr_valid,
    output logic                      fr_ready,
    input  wire hsvrgb_pkg::front_t   fr_data,
    output logic                      mx_valid,
    input  wire logic                 mx_ready,
    output hsvrgb_pkg::mix_t          mx_data
);

    logic                           mx_valid_reg;
    hsvrgb_pkg::mix_t               mx_data_reg;
    hsvrgb_pkg::mix_t               mx_data_next;
    logic                           st_ready;

    logic [hsvrgb_pkg::UNIT_W-1:0]  q_fac;
    logic [hsvrgb_pkg::UNIT_W-1:0]  t_fac;
    logic [hsvrgb_pkg::PROD_W-1:0]  p_prod;
    logic [hsvrgb_pkg::PROD_W-1:0]  q_prod;
    logic [hsvrgb_pkg::PROD_W-1:0]  t_prod;

    assign st_ready = !mx_valid_reg || mx_ready;
    assign fr_ready = st_ready;

    assign q_fac  = hsvrgb_pkg::ONE - fr_data.sf;
    assign t_fac  = hsvrgb_pkg::ONE - fr_data.s_one_m_f;
    assign p_prod = hsvrgb_pkg::PROD_W'(fr_data.val) * hsvrgb_pkg::PROD_W'(fr_data.one_m_s);
    assign q_prod = hsvrgb_pkg::PROD_W'(fr_data.val) * hsvrgb_pkg::PROD_W'(q_fac);
    assign t_prod = hsvrgb_pkg::PROD_W'(fr_data.val) * hsvrgb_pkg::PROD_W'(t_fac);

    always_comb
    begin
        mx_data_next.val   = fr_data.val;
        mx_data_next.p     = hsvrgb_pkg::UNIT_W'(p_prod >> hsvrgb_pkg::FRAC_BITS);
        mx_data_next.q     = hsvrgb_pkg::UNIT_W'(q_prod >> hsvrgb_pkg::FRAC_BITS);
        mx_data_next.t     = hsvrgb_pkg::UNIT_W'(t_prod >> hsvrgb_pkg::FRAC_BITS);
        mx_data_next.sec   = fr_data.sec;
        mx_data_next.alpha = fr_data.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mx_valid_reg <= 1'b0;
        else if (st_ready)
            mx_valid_reg <= fr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (st_ready && fr_valid)
            mx_data_reg <= mx_data_next;
    end

    assign mx_valid = mx_valid_reg;
    assign mx_data  = mx_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsvrgb_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 4: per-sector channel select and scale to bytes
module hsvrgb_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mx_valid,
    output logic                    mx_ready,
    input  wire hsvrgb_pkg::mix_t   mx_data,
    hsvrgb_out_if.source            pix_out
);

    // floor(x * 255 / one) as (x << 8) - x
    function automatic logic [hsvrgb_pkg::CH_W-1:0] to_byte(
        input logic [hsvrgb_pkg::UNIT_W-1:0] x
    );
        logic [hsvrgb_pkg::UNIT_W+hsvrgb_pkg::CH_W-1:0] sc;
        sc = {x, hsvrgb_pkg::CH_W'(0)} - (hsvrgb_pkg::UNIT_W + hsvrgb_pkg::CH_W)'(x);
        return sc[hsvrgb_pkg::FRAC_BITS+hsvrgb_pkg::CH_W-1:hsvrgb_pkg::FRAC_BITS];
    endfunction

    logic                           out_valid_reg;
    logic [hsvrgb_pkg::CH_W-1:0]    red_reg;
    logic [hsvrgb_pkg::CH_W-1:0]    green_reg;
    logic [hsvrgb_pkg::CH_W-1:0]    blue_reg;
    logic [hsvrgb_pkg::CH_W-1:0]    alpha_reg;
    logic                           st_ready;

    logic [hsvrgb_pkg::UNIT_W-1:0]  r_sel;
    logic [hsvrgb_pkg::UNIT_W-1:0]  g_sel;
    logic [hsvrgb_pkg::UNIT_W-1:0]  b_sel;

    assign st_ready = !out_valid_reg || pix_out.ready;
    assign mx_ready = st_ready;

    // Six-way channel select
    always_comb
    begin
        case (mx_data.sec)
            hsvrgb_pkg::SEC_RED:
            begin
                r_sel = mx_data.val; g_sel = mx_data.t;   b_sel = mx_data.p;
            end
            hsvrgb_pkg::SEC_YELLOW:
            begin
                r_sel = mx_data.q;   g_sel = mx_data.val; b_sel = mx_data.p;
            end
            hsvrgb_pkg::SEC_GREEN:
            begin
                r_sel = mx_data.p;   g_sel = mx_data.val; b_sel = mx_data.t;
            end
            hsvrgb_pkg::SEC_CYAN:
            begin
                r_sel = mx_data.p;   g_sel = mx_data.q;   b_sel = mx_data.val;
            end
            hsvrgb_pkg::SEC_BLUE:
            begin
                r_sel = mx_data.t;   g_sel = mx_data.p;   b_sel = mx_data.val;
            end
            default:
            begin
                r_sel = mx_data.val; g_sel = mx_data.p;   b_sel = mx_data.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (st_ready)
            out_valid_reg <= mx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (st_ready && mx_valid)
        begin
            red_reg   <= to_byte(r_sel);
            green_reg <= to_byte(g_sel);
            blue_reg  <= to_byte(b_sel);
            alpha_reg <= mx_data.alpha;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red       = red_reg;
    assign pix_out.green     = green_reg;
    assign pix_out.blue      = blue_reg;
    assign pix_out.alpha_out = alpha_reg;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB color converter with alpha pass-through.
//
// pix_in  (sink): hue, saturation, brightness in signed fixed point with
//   FRAC_BITS fraction bits, plus an alpha byte. A transfer happens on a
//   clock edge with valid and ready both high.
// pix_out (source): red, green, blue bytes and the unchanged alpha byte.
//
// Four register stages: clamp and sector split, saturation products,
// brightness products (p, q, t), channel select and byte scaling.
// A pixel passes through each stage register in turn before it shows as
// valid on pix_out. Throughput is one pixel per clock while pix_out.ready
// stays high; the pipeline stages, each with a valid bit, set that rate.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds ready low, the output holds its pixel and each
// stage keeps filling until it holds an item; up to four pixels are held
// in flight before pix_in.ready drops. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hsvrgb_in_if.sink       pix_in,
    hsvrgb_out_if.source    pix_out
);

    logic                 fr_valid;
    logic                 fr_ready;
    hsvrgb_pkg::front_t   fr_data;
    logic                 mx_valid;
    logic                 mx_ready;
    hsvrgb_pkg::mix_t     mx_data;

    hsvrgb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_data  (fr_data)
    );

    hsvrgb_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr_data  (fr_data),
        .mx_valid (mx_valid),
        .mx_ready (mx_ready),
        .mx_data  (mx_data)
    );

    hsvrgb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .mx_valid (mx_valid),
        .mx_ready (mx_ready),
        .mx_data  (mx_data),
        .pix_out  (pix_out)
    );

    // Items in flight, for checking only
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = pix_in.valid && pix_in.ready;
    assign out_xfer = pix_out.valid && pix_out.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 3'd1;
        else if (out_xfer && !in_xfer)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // Pipeline never holds more than its four stages
    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more items in flight than stages");

    // An empty pipeline always takes input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 3'd0) |-> pix_in.ready)
        else $error("empty pipeline not ready");

    // No output without an item inside
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> (inflight_reg != 3'd0))
        else $error("output valid with nothing in flight");

    // A lone transfer into an idle pipeline later shows as valid on pix_out
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && inflight_reg == 3'd0 && !pix_out.valid) |=> ##3 pix_out.valid)
        else $error("result missing after pipeline latency");

endmodule

`default_nettype wire
